/* sv/gsp_pkg.sv */
package gsp_pkg;

    localparam int NUM_MOTORS_DEF = 6;

    localparam int IDX_W       = 3;
    localparam int POS_W       = 16;
    localparam int PH_W        = 5;
    localparam int DUTY_W      = 7;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    localparam logic [PH_W-1:0]   PHASE_LAST = PH_W'(23);
    localparam logic [DUTY_W-1:0] FULL_DUTY  = DUTY_W'(100);

    localparam logic [1:0] STOP_NONE  = 2'd0;
    localparam logic [1:0] STOP_TACHO = 2'd1;
    localparam logic [1:0] STOP_SPEED = 2'd2;

    localparam logic [1:0] REG_STEP_MODE = 2'd0;
    localparam logic [1:0] REG_SPEED_IDX = 2'd1;
    localparam logic [1:0] REG_TACHO_IDX = 2'd2;

    localparam logic             STEP_MODE_RST = 1'b1;
    localparam logic [IDX_W-1:0] SPEED_IDX_RST = IDX_W'(4);
    localparam logic [IDX_W-1:0] TACHO_IDX_RST = IDX_W'(3);

    typedef struct packed {
        logic [IDX_W-1:0] motor_index;
        logic [POS_W-1:0] target_step;
        logic             clockwise;
    } tick_t;

    typedef struct packed {
        logic [IDX_W-1:0]  motor_out;
        logic [POS_W-1:0]  position_now;
        logic              drive_written;
        logic [DUTY_W-1:0] coil_one_duty;
        logic [DUTY_W-1:0] coil_two_duty;
        logic [DUTY_W-1:0] coil_three_duty;
        logic [DUTY_W-1:0] coil_four_duty;
        logic [1:0]        timer_stop;
    } result_t;

    typedef struct packed {
        logic             step_mode;
        logic [IDX_W-1:0] speed_idx;
        logic [IDX_W-1:0] tacho_idx;
    } cfg_t;

    typedef struct packed {
        logic [DUTY_W-1:0] c1;
        logic [DUTY_W-1:0] c2;
        logic [DUTY_W-1:0] c3;
        logic [DUTY_W-1:0] c4;
    } duty_t;

    // position plus its phase mod 24, kept in step so no division is needed
    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [PH_W-1:0]  phase;
    } entry_t;

    localparam logic [DUTY_W-1:0] COS_DUTY [24] = '{
        7'd85, 7'd91, 7'd100, 7'd91, 7'd85, 7'd59, 7'd39, 7'd19, 7'd0, 7'd81, 7'd61, 7'd41,
        7'd15, 7'd9, 7'd0, 7'd9, 7'd15, 7'd41, 7'd61, 7'd81, 7'd100, 7'd19, 7'd39, 7'd59
    };

    localparam logic [DUTY_W-1:0] SIN_DUTY [24] = '{
        7'd85, 7'd59, 7'd39, 7'd19, 7'd0, 7'd81, 7'd61, 7'd41, 7'd15, 7'd9, 7'd0, 7'd9,
        7'd15, 7'd41, 7'd61, 7'd81, 7'd100, 7'd19, 7'd39, 7'd59, 7'd85, 7'd91, 7'd100, 7'd91
    };

    function automatic logic [2:0] phase_mod6(input logic [PH_W-1:0] p);
        logic [PH_W-1:0] r;
        if (p < PH_W'(6))
            r = p;
        else if (p < PH_W'(12))
            r = p - PH_W'(6);
        else if (p < PH_W'(18))
            r = p - PH_W'(12);
        else
            r = p - PH_W'(18);
        return r[2:0];
    endfunction

    function automatic duty_t full_duty(input logic [2:0] q);
        duty_t d;
        d = '0;
        case (q)
            3'd0: d = '{FULL_DUTY, '0, '0, '0};
            3'd1: d = '{FULL_DUTY, FULL_DUTY, FULL_DUTY, '0};
            3'd2: d = '{'0, FULL_DUTY, FULL_DUTY, '0};
            3'd3: d = '{'0, FULL_DUTY, FULL_DUTY, FULL_DUTY};
            3'd4: d = '{'0, '0, '0, FULL_DUTY};
            3'd5: d = '{FULL_DUTY, '0, '0, FULL_DUTY};
            default: d = '0;
        endcase
        return d;
    endfunction

endpackage

/* sv/gsp_ram.sv */
module gsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* sv/gsp_cfg.sv */
module gsp_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [gsp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [gsp_pkg::APB_DATA_W-1:0] pwdata,
    output logic [gsp_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output gsp_pkg::cfg_t                  cfg
);

    import gsp_pkg::*;

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_mode <= STEP_MODE_RST;
            cfg_reg.speed_idx <= SPEED_IDX_RST;
            cfg_reg.tacho_idx <= TACHO_IDX_RST;
        end
        else if (wr_en && paddr[1:0] == 2'b00)
        begin
            unique case (paddr[3:2])
                REG_STEP_MODE: cfg_reg.step_mode <= pwdata[0];
                REG_SPEED_IDX: cfg_reg.speed_idx <= pwdata[IDX_W-1:0];
                REG_TACHO_IDX: cfg_reg.tacho_idx <= pwdata[IDX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr[3:2])
            REG_STEP_MODE: prdata = APB_DATA_W'(cfg_reg.step_mode);
            REG_SPEED_IDX: prdata = APB_DATA_W'(cfg_reg.speed_idx);
            REG_TACHO_IDX: prdata = APB_DATA_W'(cfg_reg.tacho_idx);
            default:       prdata = '0;
        endcase
    end

endmodule

/* sv/gsp_phase.sv */
module gsp_phase (
    input  gsp_pkg::cfg_t                 cfg,
    input  logic [gsp_pkg::PH_W-1:0]      phase,
    input  logic                          tacho,
    input  logic                          gauge,
    input  logic                          clockwise,
    output gsp_pkg::duty_t                duty,
    output logic                          written
);

    import gsp_pkg::*;

    logic [PH_W-1:0] p;
    logic [2:0]      q;
    duty_t           micro;

    // tachometer runs mirrored
    assign p = tacho ? (PHASE_LAST - phase) : phase;
    assign q = phase_mod6(p);

    always_comb
    begin
        micro.c1 = (p >= PH_W'(9) && p < PH_W'(21)) ? FULL_DUTY : '0;
        micro.c2 = COS_DUTY[p];
        micro.c3 = SIN_DUTY[p];
        micro.c4 = (p >= PH_W'(5) && p < PH_W'(17)) ? FULL_DUTY : '0;
    end

    assign written = gauge && (cfg.step_mode || clockwise);

    always_comb
    begin
        if (!written)
            duty = '0;
        else if (cfg.step_mode)
            duty = micro;
        else
            duty = full_duty(q);
    end

endmodule

/* sv/gauge_stepper_phase_driver_top.sv */
// Gauge stepper phase driver. Each tick beat names a motor, a target position and a direction;
// the motor's stored position moves one step toward the target and, for the speedometer and
// tachometer motors, four coil duties in percent come back in one result beat. One tick is
// taken every cycle while tick_stall is low; it passes through the s1 stage and out_reg. Positions
// live in a single-port-read position RAM (one entry per motor, with its phase mod 24 alongside);
// the tick's read is issued when it is accepted and written back when it leaves the s1 stage, and
// a write to the same motor by the tick just ahead is forwarded. Per-motor valid bits make every
// position read as zero after reset, so no clearing pass is needed. tick_stall only rises
// while a result is held by result_stall and a second tick is already in flight.
module gauge_stepper_phase_driver_top #(
    parameter int NUM_MOTORS = gsp_pkg::NUM_MOTORS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [gsp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [gsp_pkg::APB_DATA_W-1:0] pwdata,
    output logic [gsp_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    input  logic                           tick_valid,
    output logic                           tick_stall,
    input  gsp_pkg::tick_t                 tick,
    output logic                           result_valid,
    input  logic                           result_stall,
    output gsp_pkg::result_t               result
);

    import gsp_pkg::*;

    localparam int AW = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

    cfg_t cfg;

    logic                  s1_valid_reg;
    tick_t                 s1_tick_reg;
    logic                  s1_hit_reg;
    logic                  s1_vld_reg;
    entry_t                fwd_reg;
    logic [NUM_MOTORS-1:0] vld_reg;
    logic                  out_valid_reg;
    result_t               out_reg;

    logic            load_out;
    logic            s1_go;
    logic            accept;
    logic [AW+2:0]   in_ext;
    logic [AW+2:0]   s1_ext;
    logic [AW-1:0]   in_addr;
    logic [AW-1:0]   s1_addr;
    logic            in_range_in;
    logic            s1_in_range;
    entry_t          rd_entry;
    entry_t          cur;
    entry_t          nxt;
    logic            at_target;
    logic            step_down;
    logic            we;
    logic            is_tacho;
    logic            is_speed;
    duty_t           duty;
    logic            written;
    result_t         res_next;

    gsp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign load_out   = !out_valid_reg || !result_stall;
    assign s1_go      = s1_valid_reg && load_out;
    assign tick_stall = s1_valid_reg && !load_out;
    assign accept     = tick_valid && !tick_stall;

    assign in_ext      = {AW'(0), tick.motor_index};
    assign s1_ext      = {AW'(0), s1_tick_reg.motor_index};
    assign in_addr     = in_ext[AW-1:0];
    assign s1_addr     = s1_ext[AW-1:0];
    assign in_range_in = int'(tick.motor_index) < NUM_MOTORS;
    assign s1_in_range = int'(s1_tick_reg.motor_index) < NUM_MOTORS;

    gsp_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (NUM_MOTORS),
        .AW    (AW)
    ) u_pos_ram (
        .clk   (clk),
        .we    (we),
        .waddr (s1_addr),
        .wdata (nxt),
        .re    (accept),
        .raddr (in_addr),
        .rdata (rd_entry)
    );

    always_comb
    begin
        if (s1_hit_reg)
            cur = fwd_reg;
        else if (s1_vld_reg)
            cur = rd_entry;
        else
            cur = '0;
    end

    assign at_target = cur.pos == s1_tick_reg.target_step;
    assign step_down = s1_tick_reg.target_step < cur.pos;

    always_comb
    begin
        nxt = cur;
        if (!at_target)
        begin
            if (step_down)
            begin
                nxt.pos   = cur.pos - POS_W'(1);
                nxt.phase = (cur.phase == '0) ? PHASE_LAST : cur.phase - PH_W'(1);
            end
            else
            begin
                nxt.pos   = cur.pos + POS_W'(1);
                nxt.phase = (cur.phase == PHASE_LAST) ? '0 : cur.phase + PH_W'(1);
            end
        end
    end

    assign we       = s1_go && s1_in_range && !at_target;
    assign is_tacho = s1_tick_reg.motor_index == cfg.tacho_idx;
    assign is_speed = s1_tick_reg.motor_index == cfg.speed_idx;

    gsp_phase u_phase (
        .cfg       (cfg),
        .phase     (nxt.phase),
        .tacho     (is_tacho),
        .gauge     (s1_in_range && !at_target && (is_tacho || is_speed)),
        .clockwise (s1_tick_reg.clockwise),
        .duty      (duty),
        .written   (written)
    );

    always_comb
    begin
        res_next.motor_out       = s1_tick_reg.motor_index;
        res_next.position_now    = s1_in_range ? nxt.pos : '0;
        res_next.drive_written   = written;
        res_next.coil_one_duty   = duty.c1;
        res_next.coil_two_duty   = duty.c2;
        res_next.coil_three_duty = duty.c3;
        res_next.coil_four_duty  = duty.c4;
        res_next.timer_stop      = STOP_NONE;
        if (s1_in_range && at_target)
        begin
            if (is_tacho)
                res_next.timer_stop = STOP_TACHO;
            else if (is_speed)
                res_next.timer_stop = STOP_SPEED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_hit_reg    <= 1'b0;
            s1_vld_reg    <= 1'b0;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                // the ram read lands on the same edge as this write, so take it from fwd_reg
                s1_hit_reg   <= we && (s1_addr == in_addr);
                s1_vld_reg   <= in_range_in && vld_reg[in_addr];
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (we)
            begin
                vld_reg[s1_addr] <= 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_tick_reg <= tick;
        end
        if (we)
        begin
            fwd_reg <= nxt;
        end
        if (s1_go)
        begin
            out_reg <= res_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

/* sv/gsp_checker.sv */
module gsp_checker #(
    parameter int NUM_MOTORS = gsp_pkg::NUM_MOTORS_DEF
) (
    input logic             clk,
    input logic             rst_n,
    input logic             tick_valid,
    input logic             tick_stall,
    input logic             result_valid,
    input logic             result_stall,
    input gsp_pkg::result_t result
);

    import gsp_pkg::*;

    // a stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    // ticks only back up behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        tick_stall |-> result_valid && result_stall)
        else $error("tick stalled without a held result");

    // a fresh result comes from a tick accepted through the s1 stage
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(tick_valid && !tick_stall, 2))
        else $error("result without an accepted tick");

    // unknown motors give an empty result
    a_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && int'(result.motor_out) >= NUM_MOTORS |->
        result.position_now == '0 && !result.drive_written && result.timer_stop == STOP_NONE)
        else $error("out of range motor gave a nonempty result");

    // a stop code never comes with drive, and no drive means zero duties
    a_stop_no_drive: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.timer_stop != STOP_NONE || !result.drive_written) |->
        !(result.timer_stop != STOP_NONE && result.drive_written) &&
        result.coil_one_duty == '0 && result.coil_two_duty == '0 &&
        result.coil_three_duty == '0 && result.coil_four_duty == '0)
        else $error("stop code or idle drive with nonzero duties");

endmodule

bind gauge_stepper_phase_driver_top gsp_checker #(.NUM_MOTORS(NUM_MOTORS)) u_gsp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .tick_valid   (tick_valid),
    .tick_stall   (tick_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
